>>> hdl/uart_rb_pkg.sv
package uart_rb_pkg;

    // item kinds carried on the input tuser
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;

    // register offsets
    localparam logic [11:0] OFF_DR    = 12'h000;
    localparam logic [11:0] OFF_RSR   = 12'h004;
    localparam logic [11:0] OFF_FR    = 12'h018;
    localparam logic [11:0] OFF_ILPR  = 12'h020;
    localparam logic [11:0] OFF_IBRD  = 12'h024;
    localparam logic [11:0] OFF_FBRD  = 12'h028;
    localparam logic [11:0] OFF_LCR_H = 12'h02C;
    localparam logic [11:0] OFF_CR    = 12'h030;
    localparam logic [11:0] OFF_IFLS  = 12'h034;
    localparam logic [11:0] OFF_IMSC  = 12'h038;
    localparam logic [11:0] OFF_RIS   = 12'h03C;
    localparam logic [11:0] OFF_MIS   = 12'h040;
    localparam logic [11:0] OFF_ICR   = 12'h044;
    localparam logic [11:0] OFF_DMACR = 12'h048;

    // ID window 0xFE0..0xFFF: offset[11:5] all ones
    localparam logic [6:0] ID_PAGE = 7'h7F;

    // access sizes in bytes
    localparam logic [2:0] SIZE_BYTE = 3'd1;
    localparam logic [2:0] SIZE_HALF = 3'd2;
    localparam logic [2:0] SIZE_WORD = 3'd4;

    // status bit positions (FR, RIS/MIS)
    localparam int FR_RXFE  = 4;
    localparam int FR_RXFF  = 6;
    localparam int FR_TXFE  = 7;
    localparam int INT_RX   = 4;
    localparam int INT_TX   = 5;

    function automatic logic [7:0] id_word(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0: v = 8'h11;
            3'd1: v = 8'h10;
            3'd2: v = 8'h14;
            3'd3: v = 8'h00;
            3'd4: v = 8'h0D;
            3'd5: v = 8'hF0;
            3'd6: v = 8'h05;
            3'd7: v = 8'hB1;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic load;   // capture the incoming transaction
        logic exec;   // apply the item and load the result register
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_stall;  // result register full and not taken
    } t_dp_status;

endpackage

>>> hdl/uart_rb_ctrl.sv
module uart_rb_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  uart_rb_pkg::t_dp_status i_status,
    output uart_rb_pkg::t_ctrl_cmd  o_cmd
);
    import uart_rb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    t_state r_state;
    logic   r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b1;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= ST_READ;
                        r_ready <= 1'b0;
                    end
                end
                ST_READ: begin
                    // FIFO head byte is fetched this cycle
                    r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (!i_status.out_stall) begin
                        r_state <= ST_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_s_tready = r_ready;
    assign o_cmd.load = i_s_tvalid & r_ready;
    assign o_cmd.exec = (r_state == ST_EXEC) & ~i_status.out_stall;

endmodule

>>> hdl/uart_rb_dp.sv
module uart_rb_dp #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  uart_rb_pkg::t_ctrl_cmd  i_cmd,
    output uart_rb_pkg::t_dp_status o_status,
    input  logic [1:0]              i_operation,
    input  logic [11:0]             i_offset,
    input  logic [2:0]              i_access_size,
    input  logic [31:0]             i_write_data,
    input  logic [7:0]              i_rx_byte,
    input  logic                    i_m_tready,
    output logic                    o_m_tvalid,
    output logic [15:0]             o_read_data,
    output logic                    o_access_ok,
    output logic                    o_irq_level,
    output logic                    o_tx_valid,
    output logic [7:0]              o_tx_byte,
    output logic                    o_rx_dropped
);
    import uart_rb_pkg::*;

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_SUM = (AW+1)'(FIFO_DEPTH);
    localparam logic [AW-1:0] HEAD_LAST = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(FIFO_DEPTH);

    // captured transaction
    logic [1:0]  r_op;
    logic [11:0] r_off;
    logic [2:0]  r_size;
    logic [31:0] r_wdata;
    logic [7:0]  r_rxb;

    // RX FIFO
    logic [7:0]    r_mem [FIFO_DEPTH];
    logic [7:0]    r_head_byte;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;

    // programmable registers
    logic [15:0] r_ibrd;
    logic [5:0]  r_fbrd;
    logic [7:0]  r_lcr;
    logic [15:0] r_cr;
    logic [5:0]  r_ifls;
    logic [10:0] r_imsc;
    logic [2:0]  r_dmacr;

    // result register
    logic        r_out_valid;
    logic [15:0] r_out_rdata;
    logic        r_out_ok;
    logic        r_out_irq;
    logic        r_out_txv;
    logic [7:0]  r_out_txb;
    logic        r_out_drop;

    logic        w_size_ok;
    logic        w_empty;
    logic        w_full;
    logic        w_is_id;
    logic        w_rd_hit;
    logic [15:0] w_rd_val;
    logic        w_wr_hit;
    logic        w_pop;
    logic        w_push;
    logic [AW:0] w_sum;
    logic [AW-1:0] w_tail;

    logic [15:0]   n_rdata;
    logic          n_ok;
    logic          n_txv;
    logic [7:0]    n_txb;
    logic          n_drop;
    logic          n_irq;
    logic [CW-1:0] n_count;
    logic [10:0]   n_imsc;

    assign w_size_ok = (r_size == SIZE_BYTE) || (r_size == SIZE_HALF) || (r_size == SIZE_WORD);
    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count == COUNT_FULL);
    assign w_is_id   = (r_off[11:5] == ID_PAGE);

    assign w_sum  = (AW+1)'(r_head) + (AW+1)'(r_count);
    assign w_tail = (w_sum >= DEPTH_SUM) ? AW'(w_sum - DEPTH_SUM) : w_sum[AW-1:0];

    // read decode
    always_comb begin
        w_rd_hit = 1'b1;
        w_rd_val = '0;
        if (w_is_id) begin
            w_rd_hit = (r_off[1:0] == 2'b00);
            w_rd_val = w_rd_hit ? {8'h00, id_word(r_off[4:2])} : 16'h0000;
        end else begin
            case (r_off)
                OFF_DR:    w_rd_val = w_empty ? 16'h0000 : {8'h00, r_head_byte};
                OFF_RSR:   w_rd_val = '0;
                OFF_FR: begin
                    w_rd_val[FR_TXFE] = 1'b1;
                    w_rd_val[FR_RXFE] = w_empty;
                    w_rd_val[FR_RXFF] = w_full;
                end
                OFF_ILPR:  w_rd_val = '0;
                OFF_IBRD:  w_rd_val = r_ibrd;
                OFF_FBRD:  w_rd_val = {10'h000, r_fbrd};
                OFF_LCR_H: w_rd_val = {8'h00, r_lcr};
                OFF_CR:    w_rd_val = r_cr;
                OFF_IFLS:  w_rd_val = {10'h000, r_ifls};
                OFF_IMSC:  w_rd_val = {5'h00, r_imsc};
                OFF_RIS: begin
                    w_rd_val[INT_TX] = 1'b1;
                    w_rd_val[INT_RX] = ~w_empty;
                end
                OFF_MIS: begin
                    w_rd_val[INT_TX] = r_imsc[INT_TX];
                    w_rd_val[INT_RX] = r_imsc[INT_RX] & ~w_empty;
                end
                OFF_ICR:   w_rd_val = '0;
                OFF_DMACR: w_rd_val = {13'h0000, r_dmacr};
                default:   w_rd_hit = 1'b0;
            endcase
        end
    end

    // write decode: ID window and unknown offsets are refused
    always_comb begin
        case (r_off)
            OFF_DR, OFF_RSR, OFF_FR, OFF_ILPR, OFF_IBRD, OFF_FBRD, OFF_LCR_H,
            OFF_CR, OFF_IFLS, OFF_IMSC, OFF_RIS, OFF_MIS, OFF_ICR, OFF_DMACR:
                w_wr_hit = 1'b1;
            default:
                w_wr_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_rdata = '0;
        n_ok    = 1'b0;
        n_txv   = 1'b0;
        n_txb   = '0;
        n_drop  = 1'b0;
        w_pop   = 1'b0;
        w_push  = 1'b0;
        n_imsc  = r_imsc;
        case (r_op)
            OP_READ: begin
                if (w_size_ok && w_rd_hit) begin
                    n_ok    = 1'b1;
                    n_rdata = w_rd_val;
                    w_pop   = (r_off == OFF_DR) && !w_empty;
                end
            end
            OP_WRITE: begin
                if (w_size_ok && w_wr_hit) begin
                    n_ok = 1'b1;
                    if (r_off == OFF_DR) begin
                        n_txv = 1'b1;
                        n_txb = r_wdata[7:0];
                    end
                    if (r_off == OFF_IMSC) begin
                        n_imsc = r_wdata[10:0];
                    end
                end
            end
            OP_RX: begin
                n_drop = w_full;
                w_push = ~w_full;
            end
            default: begin
            end
        endcase
        n_count = r_count;
        if (w_pop) begin
            n_count = r_count - CW'(1);
        end else if (w_push) begin
            n_count = r_count + CW'(1);
        end
        // level after the item: TX cause always set, RX cause while data waits
        n_irq = n_imsc[INT_TX] | (n_imsc[INT_RX] & (n_count != '0));
    end

    // capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_off   <= i_offset;
            r_size  <= i_access_size;
            r_wdata <= i_write_data;
            r_rxb   <= i_rx_byte;
        end
    end

    // FIFO storage, registered read at the head
    always_ff @(posedge i_clk) begin
        r_head_byte <= r_mem[r_head];
        if (i_cmd.exec && w_push) begin
            r_mem[w_tail] <= r_rxb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_ibrd  <= '0;
            r_fbrd  <= '0;
            r_lcr   <= '0;
            r_cr    <= '0;
            r_ifls  <= '0;
            r_imsc  <= '0;
            r_dmacr <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
            r_imsc  <= n_imsc;
            if (w_pop) begin
                r_head <= (r_head == HEAD_LAST) ? '0 : r_head + AW'(1);
            end
            if (r_op == OP_WRITE && w_size_ok) begin
                case (r_off)
                    OFF_IBRD:  r_ibrd  <= r_wdata[15:0];
                    OFF_FBRD:  r_fbrd  <= r_wdata[5:0];
                    OFF_LCR_H: r_lcr   <= r_wdata[7:0];
                    OFF_CR:    r_cr    <= r_wdata[15:0];
                    OFF_IFLS:  r_ifls  <= r_wdata[5:0];
                    OFF_DMACR: r_dmacr <= r_wdata[2:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_rdata <= n_rdata;
            r_out_ok    <= n_ok;
            r_out_irq   <= n_irq;
            r_out_txv   <= n_txv;
            r_out_txb   <= n_txb;
            r_out_drop  <= n_drop;
        end
    end

    assign o_status.out_stall = r_out_valid & ~i_m_tready;
    assign o_m_tvalid   = r_out_valid;
    assign o_read_data  = r_out_rdata;
    assign o_access_ok  = r_out_ok;
    assign o_irq_level  = r_out_irq;
    assign o_tx_valid   = r_out_txv;
    assign o_tx_byte    = r_out_txb;
    assign o_rx_dropped = r_out_drop;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_FULL)
        else $error("rx count above depth");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_out_valid)
        else $error("executed item left no result");

    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && n_drop |=> r_count == COUNT_FULL && $stable(r_head))
        else $error("dropped byte changed fifo");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && w_pop |=> r_count == $past(r_count) - CW'(1))
        else $error("pop did not shrink fifo");

endmodule

>>> hdl/uart_register_block_top.sv
// Sequence: after an input transaction is accepted the controller fetches the RX FIFO head byte,
// then executes the item and loads the result register (controller sequence idle/fetch/execute).
// A new input transaction is accepted only once the controller is back in idle, so a result
// waiting downstream holds the execute step and with it the next input transaction.
// Reset: i_rst_n synchronous active low; clears FIFO pointers, count, control registers
// and the result valid flag. FIFO byte storage is not cleared.
module uart_register_block_top #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [11:0] offset, [14:12] access_size, [46:15] write_data, [54:47] rx_byte, [55] zero
    input  logic [55:0] i_s_tdata,
    // [1:0] operation
    input  logic [1:0]  i_s_tuser,
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] read_data, [16] access_ok, [17] irq_level, [18] tx_valid,
    // [26:19] tx_byte, [27] rx_dropped, [31:28] zero
    output logic [31:0] o_m_tdata
);
    import uart_rb_pkg::*;

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    logic [15:0] w_read_data;
    logic        w_access_ok;
    logic        w_irq_level;
    logic        w_tx_valid;
    logic [7:0]  w_tx_byte;
    logic        w_rx_dropped;

    // Controller: accepts one transaction, sequences fetch and execute,
    // waits in execute while the result register is still occupied.
    uart_rb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: register file, RX FIFO memory, decode and result register.
    uart_rb_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_operation   (i_s_tuser),
        .i_offset      (i_s_tdata[11:0]),
        .i_access_size (i_s_tdata[14:12]),
        .i_write_data  (i_s_tdata[46:15]),
        .i_rx_byte     (i_s_tdata[54:47]),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_read_data   (w_read_data),
        .o_access_ok   (w_access_ok),
        .o_irq_level   (w_irq_level),
        .o_tx_valid    (w_tx_valid),
        .o_tx_byte     (w_tx_byte),
        .o_rx_dropped  (w_rx_dropped)
    );

    // result packing, first field in the low bits
    assign o_m_tdata = {4'h0, w_rx_dropped, w_tx_byte, w_tx_valid,
                        w_irq_level, w_access_ok, w_read_data};

endmodule
